// ===== hw/rtl/plq_pkg.sv =====
// Shared types and constants for the polyline thick-quad expander.
package plq_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int HW_W     = 7;
   localparam int ROOT_W   = 7;
   localparam int OFS_W    = 8;
   localparam int BIT_W    = 3;
   localparam int VERTEX_W = 18;
   localparam int VTX_W    = 2;

   localparam logic [BIT_W-1:0] ROOT_MSB = 3'd6;
   localparam logic [VTX_W-1:0] LAST_VTX = 2'd3;

   localparam logic [7:0]  LINE_WIDTH_RST    = 8'd4;
   localparam logic [14:0] SCREEN_HEIGHT_RST = 15'd0;
   localparam logic [31:0] LINE_COLOR_RST    = 32'h800000FF;

   typedef enum logic [1:0] {
      REG_LINE_WIDTH    = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_LINE_COLOR    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  line_width;
      logic [14:0] screen_height;
      logic [31:0] line_color;
   } cfg_type;

endpackage

// ===== hw/rtl/polyline_to_thick_quads.sv =====
// Top level: expands each polyline segment into four thick-quad vertices.
//
// A request marked first (or arriving with no stored point) is taken and
// produces no vertices. A vertical segment or repeated point goes straight
// to handing out its four vertices. Any other segment is taken, then runs
// seven steps on the shared multiplier (dx^2, dy^2, hw*dx, hw*|dy| and the
// two squares), seven search steps for each of the two offsets on the
// shift-add-compare unit, and then hands out its four vertices through the
// output register; rsp_stall can hold the hand-out. For a segment, req_stall
// stays high from acceptance until the fourth vertex is loaded.
module polyline_to_thick_quads import plq_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic                          req_first_point,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VERTEX_W-1:0]    rsp_vertex_x,
   output logic signed [VERTEX_W-1:0]    rsp_vertex_y,
   output logic [31:0]                   rsp_vertex_color,
   output logic                          rsp_last_vertex,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   localparam int CB     = COORD_BITS;
   localparam int M_W    = CB + 7;
   localparam int PROD_W = 2*M_W;
   localparam int SQ_W   = 2*CB;
   localparam int LEN_W  = 2*CB + 1;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SUM_W  = (CB + 2 > VERTEX_W) ? CB + 2 : VERTEX_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_MUL5,
      ST_MUL6,
      ST_SRCH,
      ST_EMIT
   } state_type;

   cfg_type cfg;

   state_type               state_ff, state_in;
   logic                    have_prev_ff, have_prev_in;
   logic signed [CB-1:0]    prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CB-1:0]    p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic signed [CB-1:0]    p2x_ff, p2x_in, p2y_ff, p2y_in;
   logic [CB-1:0]           dx_ff, dx_in, dy_ff, dy_in;
   logic                    mirror_ff, mirror_in;
   logic [HW_W-1:0]         hw_ff, hw_in;
   logic [SQ_W-1:0]         sqdx_ff, sqdx_in;
   logic [LEN_W-1:0]        len2_ff, len2_in;
   logic [M_W-1:0]          ay_ff, ay_in, ax_ff, ax_in;
   logic [PROD_W-1:0]       rhsy_ff, rhsy_in, rhsx_ff, rhsx_in;
   logic [ACC_W-1:0]        acc_sq_ff, acc_sq_in, acc_lin_ff, acc_lin_in;
   logic [ROOT_W-1:0]       root_ff, root_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic                    sel_x_ff, sel_x_in;
   logic [OFS_W-1:0]        xt_ff, xt_in, yt_ff, yt_in;
   logic [VTX_W-1:0]        vtx_ff, vtx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [31:0]             rsp_color_ff, rsp_color_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    swap;
   logic signed [CB-1:0]    ord_p1x, ord_p1y, ord_p2x, ord_p2y;
   logic [CB:0]             dx_w, dy_w, dy_neg_w;
   logic [HW_W-1:0]         hw_cfg;
   logic                    thin_cfg, thin;
   logic [M_W-1:0]          mul_a, mul_b;
   logic [PROD_W-1:0]       mul_prod;
   logic [ACC_W-1:0]        step_sq, step_lin;
   logic [ROOT_W-1:0]       step_root;
   logic                    load, rsp_fire;
   logic signed [CB-1:0]    px, py;
   logic                    x_plus, y_plus;
   logic [SUM_W-1:0]        px_ext, py_ext, xt_ext, yt_ext, vx_sum, py_sum, vy_sum;

   plq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   plq_mul #(.OP_W(M_W)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_prod)
   );

   plq_root #(.COORD_BITS(CB)) u_root (
      .bit_idx   (bit_ff),
      .acc_sq    (acc_sq_ff),
      .acc_lin   (acc_lin_ff),
      .root      (root_ff),
      .len2      (len2_ff),
      .rhs       (sel_x_ff ? rhsx_ff : rhsy_ff),
      .sq_next   (step_sq),
      .lin_next  (step_lin),
      .root_next (step_root)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_x     = rsp_x_ff;
   assign rsp_vertex_y     = rsp_y_ff;
   assign rsp_vertex_color = rsp_color_ff;
   assign rsp_last_vertex  = rsp_last_ff;

   // order the segment by x
   assign swap     = prev_x_ff > req_point_x;
   assign ord_p1x  = swap ? req_point_x : prev_x_ff;
   assign ord_p1y  = swap ? req_point_y : prev_y_ff;
   assign ord_p2x  = swap ? prev_x_ff : req_point_x;
   assign ord_p2y  = swap ? prev_y_ff : req_point_y;
   assign dx_w     = {ord_p2x[CB-1], ord_p2x} - {ord_p1x[CB-1], ord_p1x};
   assign dy_w     = {ord_p2y[CB-1], ord_p2y} - {ord_p1y[CB-1], ord_p1y};
   assign dy_neg_w = -dy_w;

   assign hw_cfg   = cfg.line_width[7:1];
   assign thin_cfg = (hw_cfg[HW_W-1:1] == '0);
   assign thin     = (hw_ff[HW_W-1:1] == '0);

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         ST_MUL0: begin
            mul_a = M_W'(dx_ff);
            mul_b = M_W'(dx_ff);
         end
         ST_MUL1: begin
            mul_a = M_W'(dy_ff);
            mul_b = M_W'(dy_ff);
         end
         ST_MUL2: begin
            mul_a = M_W'(hw_ff);
            mul_b = M_W'(dx_ff);
         end
         ST_MUL3: begin
            mul_a = M_W'(hw_ff);
            mul_b = M_W'(dy_ff);
         end
         ST_MUL4: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         ST_MUL5: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // vertex datapath
   assign load     = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_fire = rsp_valid_ff && !rsp_stall;
   assign px       = vtx_ff[1] ? p2x_ff : p1x_ff;
   assign py       = vtx_ff[1] ? p2y_ff : p1y_ff;
   assign x_plus   = (vtx_ff[1] == vtx_ff[0]) ^ mirror_ff;
   assign y_plus   = vtx_ff[1] ^ vtx_ff[0];
   assign px_ext   = SUM_W'(px);
   assign py_ext   = SUM_W'(py);
   assign xt_ext   = SUM_W'(xt_ff);
   assign yt_ext   = SUM_W'(yt_ff);
   assign vx_sum   = x_plus ? px_ext + xt_ext : px_ext - xt_ext;
   assign py_sum   = y_plus ? py_ext + yt_ext : py_ext - yt_ext;
   assign vy_sum   = SUM_W'(cfg.screen_height) - py_sum;

   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      p1x_in       = p1x_ff;
      p1y_in       = p1y_ff;
      p2x_in       = p2x_ff;
      p2y_in       = p2y_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      mirror_in    = mirror_ff;
      hw_in        = hw_ff;
      sqdx_in      = sqdx_ff;
      len2_in      = len2_ff;
      ay_in        = ay_ff;
      ax_in        = ax_ff;
      rhsy_in      = rhsy_ff;
      rhsx_in      = rhsx_ff;
      acc_sq_in    = acc_sq_ff;
      acc_lin_in   = acc_lin_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      sel_x_in     = sel_x_ff;
      xt_in        = xt_ff;
      yt_in        = yt_ff;
      vtx_in       = vtx_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               prev_x_in    = req_point_x;
               prev_y_in    = req_point_y;
               have_prev_in = 1'b1;
               if (!req_first_point && have_prev_ff) begin
                  p1x_in    = ord_p1x;
                  p1y_in    = ord_p1y;
                  p2x_in    = ord_p2x;
                  p2y_in    = ord_p2y;
                  dx_in     = dx_w[CB-1:0];
                  dy_in     = dy_w[CB] ? dy_neg_w[CB-1:0] : dy_w[CB-1:0];
                  hw_in     = hw_cfg;
                  vtx_in    = '0;
                  if (dx_w == '0) begin
                     mirror_in = 1'b0;
                     xt_in     = OFS_W'(hw_cfg) + OFS_W'(thin_cfg);
                     yt_in     = OFS_W'(thin_cfg);
                     state_in  = ST_EMIT;
                  end else begin
                     mirror_in = dy_w[CB];
                     state_in  = ST_MUL0;
                  end
               end
            end
         end
         ST_MUL0: begin
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            sqdx_in  = mul_prod[SQ_W-1:0];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            len2_in  = LEN_W'(sqdx_ff) + LEN_W'(mul_prod[SQ_W-1:0]);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            ay_in    = mul_prod[M_W-1:0];
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            ax_in    = mul_prod[M_W-1:0];
            state_in = ST_MUL5;
         end
         ST_MUL5: begin
            rhsy_in  = mul_prod;
            state_in = ST_MUL6;
         end
         ST_MUL6: begin
            rhsx_in    = mul_prod;
            acc_sq_in  = '0;
            acc_lin_in = '0;
            root_in    = '0;
            bit_in     = ROOT_MSB;
            sel_x_in   = 1'b0;
            state_in   = ST_SRCH;
         end
         ST_SRCH: begin
            acc_sq_in  = step_sq;
            acc_lin_in = step_lin;
            root_in    = step_root;
            bit_in     = bit_ff - 3'd1;
            if (bit_ff == '0) begin
               if (!sel_x_ff) begin
                  yt_in      = OFS_W'(step_root) + OFS_W'(thin);
                  sel_x_in   = 1'b1;
                  acc_sq_in  = '0;
                  acc_lin_in = '0;
                  root_in    = '0;
                  bit_in     = ROOT_MSB;
               end else begin
                  xt_in    = OFS_W'(step_root) + OFS_W'(thin);
                  vtx_in   = '0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = vx_sum[VERTEX_W-1:0];
               rsp_y_in     = vy_sum[VERTEX_W-1:0];
               rsp_color_in = cfg.line_color;
               rsp_last_in  = (vtx_ff == LAST_VTX);
               if (vtx_ff == LAST_VTX) begin
                  vtx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  vtx_in = vtx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         vtx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         vtx_ff       <= vtx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1x_ff       <= p1x_in;
      p1y_ff       <= p1y_in;
      p2x_ff       <= p2x_in;
      p2y_ff       <= p2y_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      mirror_ff    <= mirror_in;
      hw_ff        <= hw_in;
      sqdx_ff      <= sqdx_in;
      len2_ff      <= len2_in;
      ay_ff        <= ay_in;
      ax_ff        <= ax_in;
      rhsy_ff      <= rhsy_in;
      rhsx_ff      <= rhsx_in;
      acc_sq_ff    <= acc_sq_in;
      acc_lin_ff   <= acc_lin_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      sel_x_ff     <= sel_x_in;
      xt_ff        <= xt_in;
      yt_ff        <= yt_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> (xt_ff <= {1'b0, hw_ff} + 8'd1) && (yt_ff <= {1'b0, hw_ff} + 8'd1))
      else $error("quad offset exceeds half width");

   a_vtx_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_EMIT |-> vtx_ff == '0)
      else $error("vertex counter not cleared outside emit");

   a_last_vertex: assert property (@(posedge clock) disable iff (reset)
      load && vtx_ff == LAST_VTX |=> rsp_valid_ff && rsp_last_ff && state_ff == ST_IDLE)
      else $error("fourth vertex not flagged or sequencer not released");

   a_no_vertical_search: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SRCH |-> dx_ff != '0)
      else $error("root search entered for a vertical segment");

endmodule

// ===== hw/rtl/plq_csr.sv =====
// Configuration register file behind the APB-style port.
module plq_csr import plq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index_type'(csr_paddr[3:2]))
            REG_LINE_WIDTH: begin
               cfg_in.line_width = csr_pwdata[7:0];
            end
            REG_SCREEN_HEIGHT: begin
               cfg_in.screen_height = csr_pwdata[14:0];
            end
            REG_LINE_COLOR: begin
               cfg_in.line_color = csr_pwdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[3:2]))
         REG_LINE_WIDTH: begin
            csr_prdata = {24'd0, cfg_ff.line_width};
         end
         REG_SCREEN_HEIGHT: begin
            csr_prdata = {17'd0, cfg_ff.screen_height};
         end
         REG_LINE_COLOR: begin
            csr_prdata = cfg_ff.line_color;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width    <= LINE_WIDTH_RST;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RST;
         cfg_ff.line_color    <= LINE_COLOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/plq_mul.sv =====
// Shared registered multiplier used by the segment sequencer.
module plq_mul #(
   parameter int OP_W = 23
) (
   input  logic                clock,
   input  logic [OP_W-1:0]     op_a,
   input  logic [OP_W-1:0]     op_b,
   output logic [2*OP_W-1:0]   prod
);

   logic [2*OP_W-1:0] prod_ff, prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hw/rtl/plq_root.sv =====
// One bit step of the offset root search: trial by shift and add, then compare.
module plq_root import plq_pkg::*; #(
   parameter int COORD_BITS = 16
) (
   input  logic [BIT_W-1:0]              bit_idx,
   input  logic [2*COORD_BITS+14:0]      acc_sq,
   input  logic [2*COORD_BITS+14:0]      acc_lin,
   input  logic [ROOT_W-1:0]             root,
   input  logic [2*COORD_BITS:0]         len2,
   input  logic [2*COORD_BITS+13:0]      rhs,
   output logic [2*COORD_BITS+14:0]      sq_next,
   output logic [2*COORD_BITS+14:0]      lin_next,
   output logic [ROOT_W-1:0]             root_next
);

   localparam int ACC_W = 2*COORD_BITS+15;

   logic [ACC_W-1:0] len_ext;
   logic [ACC_W-1:0] trial;
   logic [3:0]       sh_lin;
   logic [3:0]       sh_len;
   logic             take;

   assign len_ext = ACC_W'(len2);
   assign sh_lin  = {1'b0, bit_idx} + 4'd1;
   assign sh_len  = {bit_idx, 1'b0};

   // (q + 2^b)^2 * len2 = q^2*len2 + (q*len2) << (b+1) + len2 << 2b
   assign trial = acc_sq + (acc_lin << sh_lin) + (len_ext << sh_len);
   assign take  = trial <= ACC_W'(rhs);

   assign sq_next   = take ? trial : acc_sq;
   assign lin_next  = take ? acc_lin + (len_ext << bit_idx) : acc_lin;
   assign root_next = take ? root | (ROOT_W'(1) << bit_idx) : root;

endmodule
